// File: hw/rtl/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

    // default depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // replacement character
    localparam logic [15:0] UNIT_REPL = 16'hFFFD;

    // surrogate bases and code point limits
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] CP_MIN_2     = 21'h000080;
    localparam logic [20:0] CP_MIN_3     = 21'h000800;
    localparam logic [20:0] CP_MIN_4     = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;

    // number of units after the leading replacements
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_ONE  = 2'd1;
    localparam logic [1:0] TAIL_PAIR = 2'd2;

    // one classified byte: replacements first, then the tail units
    typedef struct packed {
        logic [1:0]  n_rep;
        logic [1:0]  tail_cnt;
        logic        tail_rep;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        eot;
    } u8u16_job_t;

endpackage

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// top level of the utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per transaction (push/full) and delivers UTF-16 code units
// (empty/pop), one per cycle while pop is high. The front part accepts a byte every
// cycle while the job queue (QUEUE_DEPTH entries) has room; a byte that completes or
// breaks a sequence becomes one job of up to four units. The back part retires one
// unit per cycle while pop is high, so well-formed text runs at one byte per cycle
// except that a code point above U+FFFF yields a surrogate pair of two units, and runs
// of replacements for malformed input fill the queue and hold full high until it
// drains. A byte's first result passes through the job queue and then the current-job
// register of the back part before it reaches the result ports. Lead bytes give no
// result until their sequence completes or is cut off.
module utf8_to_utf16_transcoder
#(
    parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] code_unit,
    output logic        replaced,
    output logic        run_last,
    output logic        text_last
);
    import u8u16_pkg::*;

    logic        in_take;
    logic        job_valid;
    u8u16_job_t  job_front;
    u8u16_job_t  job_head;
    logic        q_full;
    logic        q_nonempty;
    logic        job_take;

    assign full    = q_full;
    assign in_take = push && !q_full;

    // byte classification
    u8u16_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .job_valid   (job_valid),
        .job         (job_front)
    );

    // job queue
    u8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_valid),
        .wr_data  (job_front),
        .full     (q_full),
        .rd_en    (job_take),
        .rd_data  (job_head),
        .nonempty (q_nonempty)
    );

    // unit emission
    u8u16_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_nonempty),
        .job_in    (job_head),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .code_unit (code_unit),
        .replaced  (replaced),
        .run_last  (run_last),
        .text_last (text_last)
    );

endmodule

// File: hw/rtl/u8u16_front.sv
// front part: sequence state and classification of each byte into a job
module u8u16_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_take,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_text,
    output logic                   job_valid,
    output u8u16_pkg::u8u16_job_t  job
);
    import u8u16_pkg::*;

    logic [1:0]  seq_len_reg, seq_len_next;
    logic [1:0]  seen_reg, seen_next;
    logic [20:0] part_reg, part_next;

    logic        pending, is_cont;
    logic [1:0]  seen_inc;
    logic [20:0] cp_new;
    logic        cp_bad;
    logic [19:0] cp_off;

    logic        st_ascii, st_lead;
    logic [1:0]  st_len;
    logic [20:0] st_part;

    assign pending  = (seq_len_reg != 2'd0);
    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign seen_inc = seen_reg + 2'd1;
    assign cp_new   = {part_reg[14:0], in_byte[5:0]};
    assign cp_off   = 20'(cp_new - CP_MIN_4);

    // range checks of a completed sequence
    always_comb
    begin
        case (seq_len_reg)
            2'd1:    cp_bad = (cp_new < CP_MIN_2);
            2'd2:    cp_bad = (cp_new < CP_MIN_3) ||
                              ((cp_new >= CP_SURR_LO) && (cp_new <= CP_SURR_HI));
            default: cp_bad = (cp_new < CP_MIN_4) || (cp_new > CP_MAX);
        endcase
    end

    // classification of a byte with no sequence pending
    always_comb
    begin
        st_ascii = (in_byte[7] == 1'b0);
        st_lead  = 1'b1;
        st_len   = 2'd0;
        st_part  = '0;
        if (in_byte[7:5] == 3'b110)
        begin
            st_len  = 2'd1;
            st_part = {16'd0, in_byte[4:0]};
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            st_len  = 2'd2;
            st_part = {17'd0, in_byte[3:0]};
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            st_len  = 2'd3;
            st_part = {18'd0, in_byte[2:0]};
        end
        else
        begin
            st_lead = 1'b0;
        end
    end

    // job and next sequence state
    always_comb
    begin
        seq_len_next  = seq_len_reg;
        seen_next     = seen_reg;
        part_next     = part_reg;
        job.n_rep     = 2'd0;
        job.tail_cnt  = TAIL_NONE;
        job.tail_rep  = 1'b0;
        job.unit0     = UNIT_REPL;
        job.unit1     = UNIT_REPL;
        job.eot       = end_of_text;

        if (pending && is_cont)
        begin
            part_next = cp_new;
            seen_next = seen_inc;
            if (seen_inc >= seq_len_reg)
            begin
                seq_len_next = 2'd0;
                seen_next    = 2'd0;
                part_next    = '0;
                if (cp_bad)
                begin
                    job.tail_cnt = TAIL_ONE;
                    job.tail_rep = 1'b1;
                end
                else if (cp_new > 21'h00FFFF)
                begin
                    job.tail_cnt = TAIL_PAIR;
                    job.unit0    = SURR_HI_BASE + {6'd0, cp_off[19:10]};
                    job.unit1    = SURR_LO_BASE + {6'd0, cp_off[9:0]};
                end
                else
                begin
                    job.tail_cnt = TAIL_ONE;
                    job.unit0    = cp_new[15:0];
                end
            end
            else if (end_of_text)
            begin
                job.n_rep = seen_inc + 2'd1;
            end
        end
        else
        begin
            // truncated sequence: one replacement per buffered byte
            if (pending)
            begin
                job.n_rep = seen_inc;
            end
            seq_len_next = 2'd0;
            seen_next    = 2'd0;
            part_next    = '0;
            if (st_ascii)
            begin
                job.tail_cnt = TAIL_ONE;
                job.unit0    = {8'd0, in_byte};
            end
            else if (st_lead)
            begin
                if (end_of_text)
                begin
                    job.tail_cnt = TAIL_ONE;
                    job.tail_rep = 1'b1;
                end
                else
                begin
                    seq_len_next = st_len;
                    part_next    = st_part;
                end
            end
            else
            begin
                job.tail_cnt = TAIL_ONE;
                job.tail_rep = 1'b1;
            end
        end

        if (end_of_text)
        begin
            seq_len_next = 2'd0;
            seen_next    = 2'd0;
            part_next    = '0;
        end
    end

    assign job_valid = in_take && ((job.n_rep != 2'd0) || (job.tail_cnt != TAIL_NONE));

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= 2'd0;
            seen_reg    <= 2'd0;
            part_reg    <= '0;
        end
        else if (in_take)
        begin
            seq_len_reg <= seq_len_next;
            seen_reg    <= seen_next;
            part_reg    <= part_next;
        end
    end

endmodule

// File: hw/rtl/u8u16_queue.sv
// job queue between the front and back parts
module u8u16_queue
#(
    parameter int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  u8u16_pkg::u8u16_job_t  wr_data,
    output logic                   full,
    input  logic                   rd_en,
    output u8u16_pkg::u8u16_job_t  rd_data,
    output logic                   nonempty
);
    import u8u16_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8u16_job_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/u8u16_back.sv
// back part: expands one job into its code units, one transaction per cycle while pop is high
module u8u16_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_avail,
    input  u8u16_pkg::u8u16_job_t  job_in,
    output logic                   job_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [15:0]            code_unit,
    output logic                   replaced,
    output logic                   run_last,
    output logic                   text_last
);
    import u8u16_pkg::*;

    u8u16_job_t  cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;

    logic [2:0]  total;
    logic [1:0]  tail_idx;
    logic        is_last;
    logic        retire;

    assign total    = {1'b0, cur_reg.n_rep} + {1'b0, cur_reg.tail_cnt};
    assign tail_idx = idx_reg - cur_reg.n_rep;
    assign is_last  = ({1'b0, idx_reg} == (total - 3'd1));
    assign retire   = cur_valid_reg && pop && is_last;
    assign job_take = job_avail && (!cur_valid_reg || retire);
    assign empty    = !cur_valid_reg;

    // unit selection for the current index
    always_comb
    begin
        if (idx_reg < cur_reg.n_rep)
        begin
            code_unit = UNIT_REPL;
            replaced  = 1'b1;
        end
        else if (tail_idx == 2'd0)
        begin
            code_unit = cur_reg.unit0;
            replaced  = cur_reg.tail_rep;
        end
        else
        begin
            code_unit = cur_reg.unit1;
            replaced  = 1'b0;
        end
    end

    assign run_last  = is_last;
    assign text_last = is_last && cur_reg.eot;

    // current job and result index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (job_take)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (retire)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (cur_valid_reg && pop)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // job payload
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job_in;
        end
    end

endmodule

// File: tb/sv/utf8_to_utf16_checker.sv
`timescale 1ns / 1ps
// checker that decodes the accepted bytes and compares the utf-16 units of the transcoder
module utf8_to_utf16_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] code_unit,
    input  logic        replaced,
    input  logic        run_last,
    input  logic        text_last,
    output int unsigned error_count,
    output int unsigned units_in_flight
);

    localparam int unsigned REPORT_LIMIT = 10;

    // one utf-16 unit as the transcoder should deliver it
    typedef struct packed {
        logic [15:0] value;
        logic        rep;
        logic        run_end;
        logic        text_end;
    } utf16_unit_t;

    // decoder state: continuation bytes needed, seen so far, code point bits
    logic [1:0]  need_conts;
    logic [1:0]  got_conts;
    logic [20:0] cp_acc;

    utf16_unit_t step_units[$];
    utf16_unit_t decoded_units[$];
    utf16_unit_t want;

    task automatic add_unit(input logic [15:0] value, input logic rep);
        utf16_unit_t u;
        u.value    = value;
        u.rep      = rep;
        u.run_end  = 1'b0;
        u.text_end = 1'b0;
        step_units = {step_units, u};
    endtask

    task automatic add_replacements(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            add_unit(u8u16_pkg::UNIT_REPL, 1'b1);
    endtask

    task automatic clear_pending();
        need_conts = 2'd0;
        got_conts  = 2'd0;
        cp_acc     = '0;
    endtask

    // decode a byte with no sequence pending
    task automatic start_fresh(input logic [7:0] b, input logic eot);
        if (b[7] == 1'b0)
            add_unit({8'h00, b}, 1'b0);
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
        begin
            if (b[7:5] == 3'b110)
            begin
                need_conts = 2'd1;
                cp_acc     = {16'h0000, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                need_conts = 2'd2;
                cp_acc     = {17'h00000, b[3:0]};
            end
            else
            begin
                need_conts = 2'd3;
                cp_acc     = {18'h00000, b[2:0]};
            end
            got_conts = 2'd0;
            // lead byte alone at the end of the text
            if (eot)
            begin
                add_unit(u8u16_pkg::UNIT_REPL, 1'b1);
                clear_pending();
            end
        end
        else
            add_unit(u8u16_pkg::UNIT_REPL, 1'b1);
    endtask

    // work out the units that one accepted byte causes
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic [20:0] cp;
        logic [20:0] offset;
        logic        bad;
        utf16_unit_t u;
        int          last;

        step_units.delete();
        if (need_conts != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                got_conts = got_conts + 2'd1;
                if (got_conts >= need_conts)
                begin
                    cp = cp_acc;
                    case (need_conts)
                        2'd1:    bad = cp < u8u16_pkg::CP_MIN_2;
                        2'd2:    bad = cp < u8u16_pkg::CP_MIN_3 ||
                                       (cp >= u8u16_pkg::CP_SURR_LO &&
                                        cp <= u8u16_pkg::CP_SURR_HI);
                        default: bad = cp < u8u16_pkg::CP_MIN_4 || cp > u8u16_pkg::CP_MAX;
                    endcase
                    if (bad)
                        add_unit(u8u16_pkg::UNIT_REPL, 1'b1);
                    else if (cp < u8u16_pkg::CP_MIN_4)
                        add_unit(cp[15:0], 1'b0);
                    else
                    begin
                        // surrogate pair
                        offset = cp - u8u16_pkg::CP_MIN_4;
                        add_unit(u8u16_pkg::SURR_HI_BASE + {6'd0, offset[19:10]}, 1'b0);
                        add_unit(u8u16_pkg::SURR_LO_BASE + {6'd0, offset[9:0]}, 1'b0);
                    end
                    clear_pending();
                end
                else if (eot)
                begin
                    // sequence cut off by the end of the text
                    add_replacements(int'(got_conts) + 1);
                    clear_pending();
                end
            end
            else
            begin
                // sequence cut off by a non-continuation byte
                add_replacements(int'(got_conts) + 1);
                clear_pending();
                start_fresh(b, eot);
            end
        end
        else
            start_fresh(b, eot);

        if (eot)
            clear_pending();

        // mark the last unit of the byte and of the text
        if (step_units.size() > 0)
        begin
            last       = step_units.size() - 1;
            u          = step_units[last];
            u.run_end  = 1'b1;
            u.text_end = eot;
            step_units[last] = u;
        end
        decoded_units = {decoded_units, step_units};
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pending();
            decoded_units.delete();
            error_count = 0;
            units_in_flight <= 0;
        end
        else
        begin
            // result transaction against the oldest decoded unit
            if (pop && !empty)
            begin
                if (decoded_units.size() == 0)
                    flag_error($sformatf("unexpected unit %h rep %b run_last %b text_last %b",
                                         code_unit, replaced, run_last, text_last));
                else
                begin
                    want = decoded_units.pop_front();
                    if (want.value !== code_unit || want.rep !== replaced ||
                        want.run_end !== run_last || want.text_end !== text_last)
                        flag_error($sformatf({"mismatch: expected unit %h rep %b run_last %b ",
                                              "text_last %b, got unit %h rep %b run_last %b ",
                                              "text_last %b"},
                                             want.value, want.rep, want.run_end, want.text_end,
                                             code_unit, replaced, run_last, text_last));
                end
            end
            // input transaction
            if (push && !full)
                decode_byte(in_byte, end_of_text);
            units_in_flight <= decoded_units.size();
        end
    end

endmodule

// File: tb/sv/utf8_to_utf16_transcoder_tb.sv
`timescale 1ns / 1ps
// testbench top of the utf-8 to utf-16 transcoder: stimulus, watchdog and verdict
module utf8_to_utf16_transcoder_tb;

    localparam int unsigned RANDOM_BYTES = 146;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned HOLD_AFTER   = 30;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        end_of_text;
    logic        empty;
    logic        pop;
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        text_last;

    int unsigned error_count;
    int unsigned units_in_flight;
    int unsigned idle_cycles;

    // byte stream to send, with the end-of-text flag of each byte
    logic [7:0] stream_bytes[$];
    bit         stream_eot[$];

    utf8_to_utf16_transcoder u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .code_unit   (code_unit),
        .replaced    (replaced),
        .run_last    (run_last),
        .text_last   (text_last)
    );

    utf8_to_utf16_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .in_byte         (in_byte),
        .end_of_text     (end_of_text),
        .empty           (empty),
        .pop             (pop),
        .code_unit       (code_unit),
        .replaced        (replaced),
        .run_last        (run_last),
        .text_last       (text_last),
        .error_count     (error_count),
        .units_in_flight (units_in_flight)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic add_byte(input logic [7:0] b, input bit eot);
        stream_bytes = {stream_bytes, b};
        stream_eot   = {stream_eot, eot};
    endtask

    // utf-8 encoding of a valid code point
    task automatic add_code_point(input logic [20:0] cp);
        if (cp < 21'h000080)
            add_byte({1'b0, cp[6:0]}, 1'b0);
        else if (cp < 21'h000800)
        begin
            add_byte({3'b110, cp[10:6]}, 1'b0);
            add_byte({2'b10, cp[5:0]}, 1'b0);
        end
        else if (cp < 21'h010000)
        begin
            add_byte({4'b1110, cp[15:12]}, 1'b0);
            add_byte({2'b10, cp[11:6]}, 1'b0);
            add_byte({2'b10, cp[5:0]}, 1'b0);
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]}, 1'b0);
            add_byte({2'b10, cp[17:12]}, 1'b0);
            add_byte({2'b10, cp[11:6]}, 1'b0);
            add_byte({2'b10, cp[5:0]}, 1'b0);
        end
    endtask

    // lead byte of a given sequence length with random payload and continuations
    task automatic add_lead_run(input int unsigned seq_bytes, input int unsigned conts);
        logic [7:0] r;
        r = 8'($urandom);
        case (seq_bytes)
            2:       add_byte({3'b110, r[4:0]}, 1'b0);
            3:       add_byte({4'b1110, r[3:0]}, 1'b0);
            default: add_byte({5'b11110, r[2:0]}, 1'b0);
        endcase
        for (int unsigned k = 0; k < conts; k++)
        begin
            r = 8'($urandom);
            add_byte({2'b10, r[5:0]}, 1'b0);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned directed_count;
        int unsigned kind;
        int unsigned seq_bytes;
        int unsigned gap;
        logic [20:0] cp;

        push        <= 1'b0;
        in_byte     <= 8'h00;
        end_of_text <= 1'b0;
        rst_n       <= 1'b0;

        // directed part
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        // overlong two-byte form
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_code_point(21'h0007FF);
        // surrogate code point
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        // validly encoded replacement character
        add_code_point(21'h00FFFD);
        add_code_point(21'h10FFFF);
        // invalid lead, then stray continuation
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        // sequence cut off by an ascii byte
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'h41, 1'b0);
        // sequence cut off by the end of the text
        add_byte(8'hF0, 1'b0);
        add_byte(8'h90, 1'b1);
        // lead byte alone at the end of the text
        add_byte(8'hC3, 1'b1);
        directed_count = stream_bytes.size();

        // random part: mostly well-formed, then random-content, truncated and noise
        while (stream_bytes.size() < directed_count + RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                case ($urandom_range(1, 4))
                    1: cp = 21'($urandom_range(21'h000000, 21'h00007F));
                    2: cp = 21'($urandom_range(21'h000080, 21'h0007FF));
                    3:
                    begin
                        cp = 21'($urandom_range(21'h000800, 21'h00FFFF));
                        while (cp >= 21'h00D800 && cp <= 21'h00DFFF)
                            cp = 21'($urandom_range(21'h000800, 21'h00FFFF));
                    end
                    default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
                endcase
                add_code_point(cp);
            end
            else if (kind < 75)
            begin
                seq_bytes = $urandom_range(2, 4);
                add_lead_run(seq_bytes, seq_bytes - 1);
            end
            else if (kind < 90)
            begin
                seq_bytes = $urandom_range(2, 4);
                add_lead_run(seq_bytes, $urandom_range(0, seq_bytes - 2));
            end
            else
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 5) == 0)
                stream_eot[stream_eot.size() - 1] = 1'b1;
        end
        stream_eot[stream_eot.size() - 1] = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // offer the bytes, with a stretch without gaps every few dozen
        for (int i = 0; i < stream_bytes.size(); i++)
        begin
            gap = ((i / 32) % 3 == 1) ? 0 : pick_gap();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push        <= 1'b1;
            in_byte     <= stream_bytes[i];
            end_of_text <= stream_eot[i];
            do
                @(posedge clk);
            while (full);
        end
        push <= 1'b0;

        // wait for the last units, then let the pipeline settle
        @(posedge clk);
        while (units_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("[utf8_to_utf16_transcoder] OK");
        else
            $display("[utf8_to_utf16_transcoder] ERROR");
        $finish;
    end

    // receiver: random stalls, one long hold-off to fill the block
    initial
    begin
        int unsigned taken;
        int unsigned stall;
        bit          held;

        pop   <= 1'b0;
        taken = 0;
        held  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && taken == HOLD_AFTER)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else if ((taken / 40) % 3 == 1)
                stall = 0;
            else
                stall = pick_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            taken++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("[utf8_to_utf16_transcoder] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
